// ===== hw/rtl/smm_pkg.sv =====
// ----------------------------------------------------------------------------
// Switch event MIDI mapper package
// Shared codes, message entry layout, packet constants and the control and
// status bundles passed between the controller and the datapath.
// ----------------------------------------------------------------------------
package smm_pkg;

    localparam int SWITCH_COUNT_DEF       = 16;
    localparam int MESSAGES_PER_EVENT_DEF = 10;

    // Item operations.
    typedef enum logic [1:0] {
        OP_SAMPLE      = 2'd0,
        OP_WRITE_SLOT  = 2'd1,
        OP_WRITE_COUNT = 2'd2
    } t_op;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_DEBOUNCE = 2'd0,
        CFG_CABLE    = 2'd1,
        CFG_SWITCHES = 2'd2
    } t_cfg_reg;

    // Message types held in the table.
    typedef enum logic [1:0] {
        MT_NONE = 2'd0,
        MT_CC   = 2'd1,
        MT_PC   = 2'd2,
        MT_NOTE = 2'd3
    } t_mtype;

    localparam logic [15:0] DEBOUNCE_RST = 16'd20;
    localparam logic [3:0]  CABLE_RST    = 4'd0;
    localparam logic [4:0]  SWITCHES_RST = 5'd2;

    localparam logic [3:0] CIN_CC       = 4'hB;
    localparam logic [3:0] CIN_PC       = 4'hC;
    localparam logic [3:0] CIN_NOTE_ON  = 4'h9;
    localparam logic [3:0] CIN_NOTE_OFF = 4'h8;

    localparam logic [7:0] STATUS_CC       = 8'hB0;
    localparam logic [7:0] STATUS_PC       = 8'hC0;
    localparam logic [7:0] STATUS_NOTE_ON  = 8'h90;
    localparam logic [7:0] STATUS_NOTE_OFF = 8'h80;

    localparam logic [6:0] VALUE_MAX = 7'd127;

    // One stored message, 20 bits.
    typedef struct packed {
        logic [1:0] mtype;
        logic [3:0] chan;
        logic [6:0] p1;
        logic [6:0] p2;
    } t_entry;

    // Controller to datapath.
    typedef struct packed {
        logic clear;      // write the reset entry at the clear address
        logic load;       // capture the input transaction
        logic exec;       // apply the captured item
        logic rd_en;      // read the table entry at the play index
        logic hold;       // turn the read entry into the held packet
        logic push;       // move the held packet to the output register
        logic push_last;  // the pushed packet ends the event
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic start_play; // accepted change with link up and a nonempty list
        logic rd_none;    // the read entry is of type none
        logic out_free;   // output register can take a packet this cycle
    } t_status;

endpackage

// ===== hw/rtl/smm_ctrl.sv =====
// ----------------------------------------------------------------------------
// Switch event MIDI mapper controller
// Sequences the table clearing pass, item execution and the playout of a
// message list, one table read per cycle while the output keeps up.
// ----------------------------------------------------------------------------
module smm_ctrl #(
    parameter int SWITCH_COUNT       = smm_pkg::SWITCH_COUNT_DEF,
    parameter int MESSAGES_PER_EVENT = smm_pkg::MESSAGES_PER_EVENT_DEF,
    localparam int DEPTH  = 2 * SWITCH_COUNT * MESSAGES_PER_EVENT,
    localparam int ADDR_W = $clog2(DEPTH),
    localparam int CNT_W  = $clog2(MESSAGES_PER_EVENT + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  smm_pkg::t_status     i_st,
    input  logic [CNT_W-1:0]     i_n,
    output smm_pkg::t_cmd        o_cmd,
    output logic [CNT_W-1:0]     o_idx,
    output logic [ADDR_W-1:0]    o_clr_addr
);

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_EXEC  = 4'b0100,
        S_PLAY  = 4'b1000
    } t_state;

    t_state              r_state, n_state;
    logic [ADDR_W-1:0]   r_clr_addr, n_clr_addr;
    logic [CNT_W-1:0]    r_idx, n_idx;
    logic                r_rd_pend, n_rd_pend;
    logic                r_held_v, n_held_v;

    logic consume;
    logic issue;
    logic at_end;

    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        n_idx      = r_idx;
        n_rd_pend  = r_rd_pend;
        n_held_v   = r_held_v;
        o_cmd      = '0;
        consume    = 1'b0;
        issue      = 1'b0;
        at_end     = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                n_clr_addr  = ADDR_W'(r_clr_addr + 1'b1);
                if (r_clr_addr == ADDR_W'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_idx      = '0;
                n_rd_pend  = 1'b0;
                n_held_v   = 1'b0;
                n_state    = i_st.start_play ? S_PLAY : S_IDLE;
            end
            S_PLAY: begin
                // A read entry is consumed when it is empty, when nothing is
                // held yet, or when the held packet can move on to the output.
                consume = r_rd_pend && (i_st.rd_none || !r_held_v || i_st.out_free);
                issue   = (r_idx != i_n) && (!r_rd_pend || consume);
                at_end  = (r_idx == i_n) && !r_rd_pend;

                o_cmd.rd_en = issue;
                o_cmd.hold  = consume && !i_st.rd_none;
                o_cmd.push  = (r_rd_pend && !i_st.rd_none && r_held_v && i_st.out_free)
                              || (at_end && r_held_v && i_st.out_free);
                o_cmd.push_last = at_end && r_held_v && i_st.out_free;

                if (issue) begin
                    n_idx     = CNT_W'(r_idx + 1'b1);
                    n_rd_pend = 1'b1;
                end else if (consume) begin
                    n_rd_pend = 1'b0;
                end

                if (o_cmd.hold) begin
                    n_held_v = 1'b1;
                end else if (o_cmd.push_last) begin
                    n_held_v = 1'b0;
                end

                if (at_end && (!r_held_v || i_st.out_free)) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_idx      <= '0;
            r_rd_pend  <= 1'b0;
            r_held_v   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_idx      <= n_idx;
            r_rd_pend  <= n_rd_pend;
            r_held_v   <= n_held_v;
        end
    end

    assign o_ready    = (r_state == S_IDLE);
    assign o_idx      = r_idx;
    assign o_clr_addr = r_clr_addr;

    a_idx_in_list: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PLAY) |-> (r_idx <= i_n))
        else $error("play index ran past the list length");

    a_read_only_in_play: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_pend |-> (r_state == S_PLAY))
        else $error("table read pending outside playout");

    a_idle_nothing_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_held_v)
        else $error("held packet left behind at end of event");

    a_push_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.push |-> i_st.out_free)
        else $error("packet pushed over an unaccepted output");

endmodule

// ===== hw/rtl/smm_dp.sv =====
// ----------------------------------------------------------------------------
// Switch event MIDI mapper datapath
// Configuration registers, switch level and time store, list lengths, the
// message table memory, packet formatting and the output register.
// ----------------------------------------------------------------------------
module smm_dp #(
    parameter int SWITCH_COUNT       = smm_pkg::SWITCH_COUNT_DEF,
    parameter int MESSAGES_PER_EVENT = smm_pkg::MESSAGES_PER_EVENT_DEF,
    localparam int DEPTH  = 2 * SWITCH_COUNT * MESSAGES_PER_EVENT,
    localparam int ADDR_W = $clog2(DEPTH),
    localparam int CNT_W  = $clog2(MESSAGES_PER_EVENT + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_index,
    input  logic [15:0]          i_cfg_data,
    // input item
    input  logic [1:0]           i_operation,
    input  logic [3:0]           i_switch_index,
    input  logic                 i_level,
    input  logic [31:0]          i_now_ms,
    input  logic                 i_link_up,
    input  logic                 i_event_kind,
    input  logic [3:0]           i_slot,
    input  logic [1:0]           i_message_type,
    input  logic [3:0]           i_channel,
    input  logic [6:0]           i_first_param,
    input  logic [6:0]           i_second_param,
    input  logic [3:0]           i_count,
    // controller
    input  smm_pkg::t_cmd        i_cmd,
    input  logic [CNT_W-1:0]     i_idx,
    input  logic [ADDR_W-1:0]    i_clr_addr,
    output smm_pkg::t_status     o_st,
    output logic [CNT_W-1:0]     o_n,
    // result
    input  logic                 i_ready,
    output logic                 o_valid,
    output logic [7:0]           o_packet_header,
    output logic [7:0]           o_status_byte,
    output logic [6:0]           o_data_one,
    output logic [6:0]           o_data_two,
    output logic                 o_last
);

    localparam int LIST_COUNT = 2 * SWITCH_COUNT;
    localparam int SW_IDX_W   = (SWITCH_COUNT > 1) ? $clog2(SWITCH_COUNT) : 1;
    localparam int SWX_W      = (SW_IDX_W > 4) ? SW_IDX_W : 4;
    localparam int LIM_W      = ($clog2(SWITCH_COUNT + 1) > 5) ? $clog2(SWITCH_COUNT + 1) : 5;
    localparam int CMP_W      = (CNT_W > 4) ? CNT_W : 4;
    localparam int LIST_W     = SW_IDX_W + 1;

    // Configuration registers.
    logic [15:0] r_debounce;
    logic [3:0]  r_cable;
    logic [4:0]  r_switches;

    // Captured item.
    logic [1:0]  r_op;
    logic [3:0]  r_sw;
    logic        r_lvl;
    logic [31:0] r_now;
    logic        r_link;
    logic        r_kind;
    logic [3:0]  r_slot;
    logic [1:0]  r_mtype;
    logic [3:0]  r_chan;
    logic [6:0]  r_p1;
    logic [6:0]  r_p2;
    logic [3:0]  r_cnt;

    // Per switch and per list state.
    logic        r_level [SWITCH_COUNT];
    logic [31:0] r_time  [SWITCH_COUNT];
    logic [3:0]  r_count [LIST_COUNT];

    // Message table.
    smm_pkg::t_entry r_mem [DEPTH];
    smm_pkg::t_entry r_rd_data;

    // Held and output packets.
    logic [7:0]  r_hd_header, n_hd_header;
    logic [7:0]  r_hd_status, n_hd_status;
    logic [6:0]  r_hd_d1;
    logic [6:0]  r_hd_d2, n_hd_d2;
    logic        r_out_valid;
    logic [7:0]  r_out_header;
    logic [7:0]  r_out_status;
    logic [6:0]  r_out_d1;
    logic [6:0]  r_out_d2;
    logic        r_out_last;

    logic [SWX_W-1:0]    sw_x;
    logic [SW_IDX_W-1:0] sw_idx;
    logic [LIST_W-1:0]   wr_list;
    logic [LIST_W-1:0]   play_list;
    logic [LIM_W-1:0]    limit;
    logic                served;
    logic [31:0]         elapsed;
    logic                sample_ok;
    logic                slot_wr;
    logic                count_wr;
    logic [CMP_W-1:0]    cnt_x;
    logic [ADDR_W-1:0]   slot_addr;
    logic [ADDR_W-1:0]   rd_addr;
    logic                mem_we;
    logic [ADDR_W-1:0]   wr_addr;
    smm_pkg::t_entry     wr_entry;
    smm_pkg::t_entry     clr_entry;
    smm_pkg::t_entry     new_entry;

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce <= smm_pkg::DEBOUNCE_RST;
            r_cable    <= smm_pkg::CABLE_RST;
            r_switches <= smm_pkg::SWITCHES_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                smm_pkg::CFG_DEBOUNCE: r_debounce <= i_cfg_data;
                smm_pkg::CFG_CABLE:    r_cable    <= i_cfg_data[3:0];
                smm_pkg::CFG_SWITCHES: r_switches <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Item capture
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_operation;
            r_sw    <= i_switch_index;
            r_lvl   <= i_level;
            r_now   <= i_now_ms;
            r_link  <= i_link_up;
            r_kind  <= i_event_kind;
            r_slot  <= i_slot;
            r_mtype <= i_message_type;
            r_chan  <= i_channel;
            r_p1    <= i_first_param;
            r_p2    <= i_second_param;
            r_cnt   <= i_count;
        end
    end

    // ------------------------------------------------------------------
    // Item decode
    // ------------------------------------------------------------------
    assign sw_x      = SWX_W'(r_sw);
    assign sw_idx    = sw_x[SW_IDX_W-1:0];
    assign wr_list   = {sw_idx, r_kind};
    assign play_list = {sw_idx, ~r_lvl};

    assign limit  = (LIM_W'(r_switches) > LIM_W'(SWITCH_COUNT)) ?
                    LIM_W'(SWITCH_COUNT) : LIM_W'(r_switches);
    assign served = LIM_W'(r_sw) < limit;

    // Wraps modulo 2^32 like the millisecond timer itself.
    assign elapsed = r_now - r_time[sw_idx];

    always_comb begin
        sample_ok = 1'b0;
        slot_wr   = 1'b0;
        count_wr  = 1'b0;
        if (served) begin
            case (r_op)
                smm_pkg::OP_SAMPLE:
                    sample_ok = (r_lvl != r_level[sw_idx]) && (elapsed >= 32'(r_debounce));
                smm_pkg::OP_WRITE_SLOT:
                    slot_wr = CMP_W'(r_slot) < CMP_W'(MESSAGES_PER_EVENT);
                smm_pkg::OP_WRITE_COUNT:
                    count_wr = CMP_W'(r_cnt) <= CMP_W'(MESSAGES_PER_EVENT);
                default: ;
            endcase
        end
    end

    assign cnt_x = CMP_W'(r_count[play_list]);
    assign o_n   = (cnt_x > CMP_W'(MESSAGES_PER_EVENT)) ?
                   CNT_W'(MESSAGES_PER_EVENT) : CNT_W'(cnt_x);

    assign o_st.start_play = sample_ok && r_link && (o_n != '0);
    assign o_st.rd_none    = (r_rd_data.mtype == smm_pkg::MT_NONE);
    assign o_st.out_free   = !r_out_valid || i_ready;

    // ------------------------------------------------------------------
    // Switch state and list lengths
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < SWITCH_COUNT; s++) begin
                r_level[s] <= 1'b0;
                r_time[s]  <= '0;
            end
            // Both lists of the first two switches start with one message.
            for (int l = 0; l < LIST_COUNT; l++) begin
                r_count[l] <= (l < 4) ? 4'd1 : 4'd0;
            end
        end else if (i_cmd.exec) begin
            if (sample_ok) begin
                r_level[sw_idx] <= r_lvl;
                r_time[sw_idx]  <= r_now;
            end
            if (count_wr) begin
                r_count[wr_list] <= r_cnt;
            end
        end
    end

    // ------------------------------------------------------------------
    // Message table
    // ------------------------------------------------------------------
    always_comb begin
        clr_entry = '0;
        for (int l = 0; l < 4; l++) begin
            if (l < LIST_COUNT && i_clr_addr == ADDR_W'(l * MESSAGES_PER_EVENT)) begin
                clr_entry.mtype = smm_pkg::MT_CC;
                clr_entry.chan  = 4'd0;
                clr_entry.p1    = 7'(l >> 1);
                clr_entry.p2    = ((l & 1) == 0) ? smm_pkg::VALUE_MAX : 7'd0;
            end
        end
    end

    assign new_entry.mtype = r_mtype;
    assign new_entry.chan  = r_chan;
    assign new_entry.p1    = r_p1;
    assign new_entry.p2    = r_p2;

    assign slot_addr = ADDR_W'(ADDR_W'(wr_list) * ADDR_W'(MESSAGES_PER_EVENT)
                               + ADDR_W'(r_slot));
    assign rd_addr   = ADDR_W'(ADDR_W'(play_list) * ADDR_W'(MESSAGES_PER_EVENT)
                               + ADDR_W'(i_idx));

    assign mem_we   = i_cmd.clear || (i_cmd.exec && slot_wr);
    assign wr_addr  = i_cmd.clear ? i_clr_addr : slot_addr;
    assign wr_entry = i_cmd.clear ? clr_entry : new_entry;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_addr] <= wr_entry;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // ------------------------------------------------------------------
    // Packet formatting
    // ------------------------------------------------------------------
    always_comb begin
        n_hd_header = {r_cable, smm_pkg::CIN_CC};
        n_hd_status = smm_pkg::STATUS_CC | {4'h0, r_rd_data.chan};
        n_hd_d2     = r_rd_data.p2;
        case (r_rd_data.mtype)
            smm_pkg::MT_CC: begin
                n_hd_header = {r_cable, smm_pkg::CIN_CC};
                n_hd_status = smm_pkg::STATUS_CC | {4'h0, r_rd_data.chan};
            end
            smm_pkg::MT_PC: begin
                n_hd_header = {r_cable, smm_pkg::CIN_PC};
                n_hd_status = smm_pkg::STATUS_PC | {4'h0, r_rd_data.chan};
                n_hd_d2     = 7'd0;
            end
            smm_pkg::MT_NOTE: begin
                // A zero velocity turns the note off.
                if (r_rd_data.p2 != 7'd0) begin
                    n_hd_header = {r_cable, smm_pkg::CIN_NOTE_ON};
                    n_hd_status = smm_pkg::STATUS_NOTE_ON | {4'h0, r_rd_data.chan};
                end else begin
                    n_hd_header = {r_cable, smm_pkg::CIN_NOTE_OFF};
                    n_hd_status = smm_pkg::STATUS_NOTE_OFF | {4'h0, r_rd_data.chan};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.hold) begin
            r_hd_header <= n_hd_header;
            r_hd_status <= n_hd_status;
            r_hd_d1     <= r_rd_data.p1;
            r_hd_d2     <= n_hd_d2;
        end
        if (i_cmd.push) begin
            r_out_header <= r_hd_header;
            r_out_status <= r_hd_status;
            r_out_d1     <= r_hd_d1;
            r_out_d2     <= r_hd_d2;
            r_out_last   <= i_cmd.push_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.push) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_packet_header = r_out_header;
    assign o_status_byte   = r_out_status;
    assign o_data_one      = r_out_d1;
    assign o_data_two      = r_out_d2;
    assign o_last          = r_out_last;

endmodule

// ===== hw/rtl/switch_event_midi_mapper.sv =====
// ----------------------------------------------------------------------------
// Switch event MIDI mapper
// Debounces footswitch level changes and plays the press or release message
// list of a switch as USB-MIDI packets; table and list length writes.
// ----------------------------------------------------------------------------
// Input channel (i_valid / o_ready) carries one transaction per item: a switch
// sample, a message slot write or a list length write. Output channel
// (o_valid / i_ready) carries one USB-MIDI packet per transaction, with o_last
// marking the final packet of a switch event. Configuration registers are
// written through i_cfg_we / i_cfg_index / i_cfg_data; the user must write
// them only while the block is idle; the block itself does not enforce it.
// After reset the block sweeps the message table, one entry per cycle, to load
// its default contents: 2 * SWITCH_COUNT * MESSAGES_PER_EVENT entries (320
// with the defaults). Configuration writes are taken during the sweep;
// o_ready stays low until it ends. A write or an ignored item passes through
// the load and execute states before o_ready returns. A sample plays its list
// with one table read per cycle while the output keeps up. Each packet moves
// from the table read register to the held packet and then to the output
// register. The two decouple the sides; a stalled receiver pauses the table
// reads without losing or repeating a packet.
module switch_event_midi_mapper #(
    parameter int SWITCH_COUNT       = smm_pkg::SWITCH_COUNT_DEF,
    parameter int MESSAGES_PER_EVENT = smm_pkg::MESSAGES_PER_EVENT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    // input channel
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_operation,
    input  logic [3:0]  i_switch_index,
    input  logic        i_level,
    input  logic [31:0] i_now_ms,
    input  logic        i_link_up,
    input  logic        i_event_kind,
    input  logic [3:0]  i_slot,
    input  logic [1:0]  i_message_type,
    input  logic [3:0]  i_channel,
    input  logic [6:0]  i_first_param,
    input  logic [6:0]  i_second_param,
    input  logic [3:0]  i_count,
    // output channel
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_packet_header,
    output logic [7:0]  o_status_byte,
    output logic [6:0]  o_data_one,
    output logic [6:0]  o_data_two,
    output logic        o_last
);

    localparam int DEPTH  = 2 * SWITCH_COUNT * MESSAGES_PER_EVENT;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(MESSAGES_PER_EVENT + 1);

    smm_pkg::t_cmd     cmd;
    smm_pkg::t_status  st;
    logic [CNT_W-1:0]  list_len;
    logic [CNT_W-1:0]  play_idx;
    logic [ADDR_W-1:0] clr_addr;

    smm_ctrl #(
        .SWITCH_COUNT       (SWITCH_COUNT),
        .MESSAGES_PER_EVENT (MESSAGES_PER_EVENT)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_st       (st),
        .i_n        (list_len),
        .o_cmd      (cmd),
        .o_idx      (play_idx),
        .o_clr_addr (clr_addr)
    );

    smm_dp #(
        .SWITCH_COUNT       (SWITCH_COUNT),
        .MESSAGES_PER_EVENT (MESSAGES_PER_EVENT)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_operation     (i_operation),
        .i_switch_index  (i_switch_index),
        .i_level         (i_level),
        .i_now_ms        (i_now_ms),
        .i_link_up       (i_link_up),
        .i_event_kind    (i_event_kind),
        .i_slot          (i_slot),
        .i_message_type  (i_message_type),
        .i_channel       (i_channel),
        .i_first_param   (i_first_param),
        .i_second_param  (i_second_param),
        .i_count         (i_count),
        .i_cmd           (cmd),
        .i_idx           (play_idx),
        .i_clr_addr      (clr_addr),
        .o_st            (st),
        .o_n             (list_len),
        .i_ready         (i_ready),
        .o_valid         (o_valid),
        .o_packet_header (o_packet_header),
        .o_status_byte   (o_status_byte),
        .o_data_one      (o_data_one),
        .o_data_two      (o_data_two),
        .o_last          (o_last)
    );

endmodule

// ===== bench/switch_event_midi_mapper_tb.sv =====
// ----------------------------------------------------------------------------
// Switch event MIDI mapper testbench
// Drives switch samples, message slot writes and list length writes through
// the input channel, predicts every USB-MIDI packet from a local copy of the
// switch and table state, and checks each packet on the output channel in
// order. Both channels idle at random; the configuration is changed between
// phases while the block is idle.
// ----------------------------------------------------------------------------
module switch_event_midi_mapper_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SWITCHES = smm_pkg::SWITCH_COUNT_DEF;
    localparam int SLOTS    = smm_pkg::MESSAGES_PER_EVENT_DEF;
    localparam int LISTS    = 2 * SWITCHES;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 20;

    typedef struct packed {
        logic [1:0]  op;
        logic [3:0]  sw;
        logic        level;
        logic [31:0] now;
        logic        link;
        logic        kind;
        logic [3:0]  slot;
        logic [1:0]  mtype;
        logic [3:0]  chan;
        logic [6:0]  p1;
        logic [6:0]  p2;
        logic [3:0]  cnt;
    } t_item;

    typedef struct packed {
        logic [7:0] header;
        logic [7:0] status;
        logic [6:0] d1;
        logic [6:0] d2;
        logic       last;
    } t_packet;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [15:0] i_cfg_data;
    logic        i_valid;
    logic        o_ready;
    logic [1:0]  i_operation;
    logic [3:0]  i_switch_index;
    logic        i_level;
    logic [31:0] i_now_ms;
    logic        i_link_up;
    logic        i_event_kind;
    logic [3:0]  i_slot;
    logic [1:0]  i_message_type;
    logic [3:0]  i_channel;
    logic [6:0]  i_first_param;
    logic [6:0]  i_second_param;
    logic [3:0]  i_count;
    logic        o_valid;
    logic        i_ready;
    logic [7:0]  o_packet_header;
    logic [7:0]  o_status_byte;
    logic [6:0]  o_data_one;
    logic [6:0]  o_data_two;
    logic        o_last;

    switch_event_midi_mapper u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_operation    (i_operation),
        .i_switch_index (i_switch_index),
        .i_level        (i_level),
        .i_now_ms       (i_now_ms),
        .i_link_up      (i_link_up),
        .i_event_kind   (i_event_kind),
        .i_slot         (i_slot),
        .i_message_type (i_message_type),
        .i_channel      (i_channel),
        .i_first_param  (i_first_param),
        .i_second_param (i_second_param),
        .i_count        (i_count),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_packet_header(o_packet_header),
        .o_status_byte  (o_status_byte),
        .o_data_one     (o_data_one),
        .o_data_two     (o_data_two),
        .o_last         (o_last)
    );

    // Local copy of the configuration and of the block state.
    logic [15:0]     debounce_set;
    logic [3:0]      cable_set;
    logic [4:0]      switches_set;
    logic            level_seen  [0:SWITCHES-1];
    logic [31:0]     change_time [0:SWITCHES-1];
    smm_pkg::t_entry msg_table   [0:LISTS-1][0:SLOTS-1];
    logic [3:0]      msg_count   [0:LISTS-1];

    t_packet packets_due [$];
    int      err_count = 0;
    int      shown     = 0;
    bit      rst_done  = 0;
    bit      no_idle   = 0;

    initial begin
        i_clk = 1'b0;
    end

    always #5 i_clk = ~i_clk;

    initial begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic bit is_served(input logic [3:0] sw);
        int lim;
        lim = (switches_set > SWITCHES) ? SWITCHES : switches_set;
        return sw < lim;
    endfunction

    task automatic mapper_reset_state();
        debounce_set = smm_pkg::DEBOUNCE_RST;
        cable_set    = smm_pkg::CABLE_RST;
        switches_set = smm_pkg::SWITCHES_RST;
        for (int s = 0; s < SWITCHES; s++) begin
            level_seen[s]  = 1'b0;
            change_time[s] = '0;
        end
        for (int l = 0; l < LISTS; l++) begin
            msg_count[l] = '0;
            for (int k = 0; k < SLOTS; k++) begin
                msg_table[l][k] = '0;
            end
        end
        // Switches 0 and 1 start with one control change per list.
        for (int s = 0; s < 2; s++) begin
            msg_table[2*s][0]   = {smm_pkg::MT_CC, 4'd0, 7'(s), smm_pkg::VALUE_MAX};
            msg_table[2*s+1][0] = {smm_pkg::MT_CC, 4'd0, 7'(s), 7'd0};
            msg_count[2*s]      = 4'd1;
            msg_count[2*s+1]    = 4'd1;
        end
    endtask

    // Applies one accepted transaction and queues the packets it causes.
    task automatic predict_packets(input t_item it);
        t_packet         evt [0:SLOTS-1];
        int              made;
        int              n;
        logic [4:0]      li;
        logic [31:0]     elapsed;
        smm_pkg::t_entry e;
        t_packet         p;
        made = 0;
        if (!is_served(it.sw)) begin
            return;
        end
        case (it.op)
            smm_pkg::OP_WRITE_SLOT: begin
                if (it.slot < SLOTS) begin
                    msg_table[{it.sw, it.kind}][it.slot] = {it.mtype, it.chan, it.p1, it.p2};
                end
            end
            smm_pkg::OP_WRITE_COUNT: begin
                if (it.cnt <= SLOTS) begin
                    msg_count[{it.sw, it.kind}] = it.cnt;
                end
            end
            smm_pkg::OP_SAMPLE: begin
                elapsed = it.now - change_time[it.sw];
                if (it.level != level_seen[it.sw] && elapsed >= {16'd0, debounce_set}) begin
                    level_seen[it.sw]  = it.level;
                    change_time[it.sw] = it.now;
                    if (it.link) begin
                        // Press plays the even list, release the odd one.
                        li = {it.sw, ~it.level};
                        n  = (msg_count[li] > SLOTS) ? SLOTS : msg_count[li];
                        for (int k = 0; k < n; k++) begin
                            e = msg_table[li][k];
                            if (e.mtype != smm_pkg::MT_NONE) begin
                                p.d1   = e.p1;
                                p.d2   = e.p2;
                                p.last = 1'b0;
                                case (e.mtype)
                                    smm_pkg::MT_CC: begin
                                        p.header = {cable_set, smm_pkg::CIN_CC};
                                        p.status = smm_pkg::STATUS_CC | {4'd0, e.chan};
                                    end
                                    smm_pkg::MT_PC: begin
                                        p.header = {cable_set, smm_pkg::CIN_PC};
                                        p.status = smm_pkg::STATUS_PC | {4'd0, e.chan};
                                        p.d2     = '0;
                                    end
                                    default: begin
                                        if (e.p2 != 0) begin
                                            p.header = {cable_set, smm_pkg::CIN_NOTE_ON};
                                            p.status = smm_pkg::STATUS_NOTE_ON |
                                                       {4'd0, e.chan};
                                        end else begin
                                            p.header = {cable_set, smm_pkg::CIN_NOTE_OFF};
                                            p.status = smm_pkg::STATUS_NOTE_OFF |
                                                       {4'd0, e.chan};
                                        end
                                    end
                                endcase
                                evt[made] = p;
                                made++;
                            end
                        end
                    end
                end
            end
            default: ;
        endcase
        if (made > 0) begin
            evt[made-1].last = 1'b1;
        end
        for (int k = 0; k < made; k++) begin
            packets_due.push_back(evt[k]);
        end
    endtask

    // Fields that a transaction does not use carry random values.
    function automatic t_item noise_item();
        t_item it;
        it.op    = 2'($urandom_range(0, 3));
        it.sw    = 4'($urandom_range(0, 15));
        it.level = 1'($urandom_range(0, 1));
        it.now   = $urandom();
        it.link  = 1'($urandom_range(0, 1));
        it.kind  = 1'($urandom_range(0, 1));
        it.slot  = 4'($urandom_range(0, 15));
        it.mtype = 2'($urandom_range(0, 3));
        it.chan  = 4'($urandom_range(0, 15));
        it.p1    = 7'($urandom_range(0, 127));
        it.p2    = 7'($urandom_range(0, 127));
        it.cnt   = 4'($urandom_range(0, 15));
        return it;
    endfunction

    function automatic t_item sample_item(input logic [3:0] sw, input logic level,
                                          input logic [31:0] now, input logic link);
        t_item it;
        it       = noise_item();
        it.op    = smm_pkg::OP_SAMPLE;
        it.sw    = sw;
        it.level = level;
        it.now   = now;
        it.link  = link;
        return it;
    endfunction

    function automatic t_item slot_item(input logic [3:0] sw, input logic kind,
                                        input logic [3:0] slot, input smm_pkg::t_mtype mtype,
                                        input logic [3:0] chan, input logic [6:0] p1,
                                        input logic [6:0] p2);
        t_item it;
        it       = noise_item();
        it.op    = smm_pkg::OP_WRITE_SLOT;
        it.sw    = sw;
        it.kind  = kind;
        it.slot  = slot;
        it.mtype = mtype;
        it.chan  = chan;
        it.p1    = p1;
        it.p2    = p2;
        return it;
    endfunction

    function automatic t_item count_item(input logic [3:0] sw, input logic kind,
                                         input logic [3:0] cnt);
        t_item it;
        it      = noise_item();
        it.op   = smm_pkg::OP_WRITE_COUNT;
        it.sw   = sw;
        it.kind = kind;
        it.cnt  = cnt;
        return it;
    endfunction

    // Mostly well-formed traffic on served switches, the rest noise.
    function automatic t_item random_item();
        t_item       it;
        int          lim;
        int          pick;
        logic [3:0]  sw;
        logic [31:0] now;
        lim  = (switches_set > SWITCHES) ? SWITCHES : switches_set;
        sw   = (lim > 0) ? 4'($urandom_range(0, lim - 1)) : 4'($urandom_range(0, 15));
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            case ($urandom_range(0, 9))
                0:       now = change_time[sw] + {16'd0, debounce_set} - 32'd1;
                1:       now = $urandom();
                default: now = change_time[sw] + {16'd0, debounce_set} +
                               32'($urandom_range(0, 3));
            endcase
            it = sample_item(sw, ($urandom_range(0, 7) == 0) ? level_seen[sw] : ~level_seen[sw],
                             now, $urandom_range(0, 7) != 0);
        end else if (pick < 65) begin
            it = slot_item(sw, 1'($urandom_range(0, 1)), 4'($urandom_range(0, SLOTS - 1)),
                           smm_pkg::t_mtype'($urandom_range(0, 3)),
                           4'($urandom_range(0, 15)),
                           7'($urandom_range(0, 127)),
                           ($urandom_range(0, 3) == 0) ? 7'd0 : 7'($urandom_range(0, 127)));
        end else if (pick < 77) begin
            it = count_item(sw, 1'($urandom_range(0, 1)), 4'($urandom_range(0, SLOTS)));
        end else begin
            it = noise_item();
        end
        return it;
    endfunction

    task automatic send_item(input t_item it);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_operation    <= it.op;
        i_switch_index <= it.sw;
        i_level        <= it.level;
        i_now_ms       <= it.now;
        i_link_up      <= it.link;
        i_event_kind   <= it.kind;
        i_slot         <= it.slot;
        i_message_type <= it.mtype;
        i_channel      <= it.chan;
        i_first_param  <= it.p1;
        i_second_param <= it.p2;
        i_count        <= it.cnt;
        do @(posedge i_clk); while (!o_ready);
        predict_packets(it);
    endtask

    // Items may leave no packet behind, so allow the block to finish its work.
    task automatic wait_idle();
        i_valid <= 1'b0;
        while (packets_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input smm_pkg::t_cfg_reg idx, input logic [15:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        case (idx)
            smm_pkg::CFG_DEBOUNCE: debounce_set = data;
            smm_pkg::CFG_CABLE:    cable_set    = data[3:0];
            smm_pkg::CFG_SWITCHES: switches_set = data[4:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_config(input logic [15:0] deb, input logic [15:0] cable,
                              input logic [15:0] switches);
        wait_idle();
        cfg_write(smm_pkg::CFG_DEBOUNCE, deb);
        cfg_write(smm_pkg::CFG_CABLE, cable);
        cfg_write(smm_pkg::CFG_SWITCHES, switches);
    endtask

    task automatic run_random(input int n);
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 29) == 0) begin
                no_idle = !no_idle;
            end
            send_item(random_item());
        end
    endtask

    // Default table and settings, debounce edges and the wrap of the time.
    task automatic test_defaults();
        send_item(sample_item(4'd0, 1'b1, 32'd19, 1'b1));
        send_item(sample_item(4'd0, 1'b1, 32'd20, 1'b1));
        send_item(sample_item(4'd0, 1'b1, 32'd100, 1'b1));
        send_item(sample_item(4'd0, 1'b0, 32'd39, 1'b1));
        send_item(sample_item(4'd0, 1'b0, 32'd40, 1'b1));
        send_item(sample_item(4'd2, 1'b1, 32'd1000, 1'b1));
        begin
            t_item it;
            it    = noise_item();
            it.op = OP_UNUSED;
            it.sw = 4'd1;
            send_item(it);
        end
        send_item(sample_item(4'd1, 1'b1, 32'hFFFF_FFFF, 1'b1));
        send_item(sample_item(4'd1, 1'b0, 32'h0000_0013, 1'b1));
    endtask

    // Every message type, bad slot and count writes, link down, empty lists.
    task automatic test_message_types();
        set_config(16'd0, 16'hFFFF, 16'd16);
        send_item(slot_item(4'd15, 1'b0, 4'd0, smm_pkg::MT_CC, 4'd15, 7'd127, 7'd127));
        send_item(slot_item(4'd15, 1'b0, 4'd1, smm_pkg::MT_PC, 4'd3, 7'd5, 7'd99));
        send_item(slot_item(4'd15, 1'b0, 4'd2, smm_pkg::MT_NOTE, 4'd7, 7'd60, 7'd100));
        send_item(slot_item(4'd15, 1'b0, 4'd3, smm_pkg::MT_NOTE, 4'd0, 7'd0, 7'd0));
        send_item(slot_item(4'd15, 1'b0, 4'd4, smm_pkg::MT_NONE, 4'd9, 7'd33, 7'd44));
        send_item(slot_item(4'd15, 1'b0, 4'd9, smm_pkg::MT_CC, 4'd1, 7'd2, 7'd3));
        send_item(slot_item(4'd15, 1'b0, 4'd10, smm_pkg::MT_CC, 4'd2, 7'd11, 7'd12));
        send_item(slot_item(4'd15, 1'b0, 4'd15, smm_pkg::MT_NOTE, 4'd4, 7'd13, 7'd14));
        send_item(count_item(4'd15, 1'b0, 4'd10));
        send_item(count_item(4'd15, 1'b0, 4'd11));
        send_item(slot_item(4'd15, 1'b1, 4'd0, smm_pkg::MT_NOTE, 4'd15, 7'd127, 7'd0));
        send_item(count_item(4'd15, 1'b1, 4'd1));
        send_item(sample_item(4'd15, 1'b1, 32'd5, 1'b1));
        send_item(sample_item(4'd15, 1'b0, 32'd6, 1'b0));
        send_item(sample_item(4'd15, 1'b1, 32'd7, 1'b1));
        send_item(sample_item(4'd15, 1'b0, 32'd7, 1'b1));
        send_item(count_item(4'd15, 1'b1, 4'd0));
        send_item(sample_item(4'd15, 1'b1, 32'd8, 1'b1));
        send_item(sample_item(4'd15, 1'b0, 32'd9, 1'b1));
        // A list whose entries are all of type none plays nothing.
        send_item(count_item(4'd14, 1'b0, 4'd3));
        send_item(sample_item(4'd14, 1'b1, 32'd10, 1'b1));
    endtask

    // Short random phases at the extremes of the settings.
    task automatic test_config_settings();
        set_config(16'hFFFF, 16'd0, 16'd1);
        run_random(12);
        set_config(16'd0, 16'hFFFF, 16'd0);
        run_random(12);
        set_config(16'd1, 16'($urandom()), 16'h001F);
        run_random(12);
        set_config(16'($urandom()), 16'($urandom()), 16'd16);
        run_random(12);
    endtask

    task automatic test_random();
        set_config(16'($urandom_range(0, 40)), 16'($urandom()), 16'd16);
        run_random(72);
    endtask

    // Output side: random stalls, then compare against the oldest packet due.
    initial begin
        t_packet got;
        t_packet want;
        int      stall;
        i_ready = 1'b0;
        wait (rst_done);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 4);
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
            got = {o_packet_header, o_status_byte, o_data_one, o_data_two, o_last};
            if (packets_due.size() == 0) begin
                err_count++;
                if (shown < 10) begin
                    $display("Unexpected packet: hdr %h status %h d1 %h d2 %h last %b",
                             got.header, got.status, got.d1, got.d2, got.last);
                    shown++;
                end
            end else begin
                want = packets_due.pop_front();
                if (got.header !== want.header || got.status !== want.status ||
                    got.d1 !== want.d1 || got.d2 !== want.d2 || got.last !== want.last) begin
                    err_count++;
                    if (shown < 10) begin
                        $display("Packet mismatch: expected hdr %h status %h d1 %h d2 %h last %b",
                                 want.header, want.status, want.d1, want.d2, want.last);
                        $display("                 actual   hdr %h status %h d1 %h d2 %h last %b",
                                 got.header, got.status, got.d1, got.d2, got.last);
                        shown++;
                    end
                end
            end
        end
    end

    initial begin
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_index    = smm_pkg::CFG_DEBOUNCE;
        i_cfg_data     = '0;
        i_valid        = 1'b0;
        i_operation    = smm_pkg::OP_SAMPLE;
        i_switch_index = '0;
        i_level        = 1'b0;
        i_now_ms       = '0;
        i_link_up      = 1'b0;
        i_event_kind   = 1'b0;
        i_slot         = '0;
        i_message_type = smm_pkg::MT_NONE;
        i_channel      = '0;
        i_first_param  = '0;
        i_second_param = '0;
        i_count        = '0;
        mapper_reset_state();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        rst_done = 1'b1;

        test_defaults();
        test_message_types();
        test_config_settings();
        test_random();
        wait_idle();

        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/smm_pkg.sv
hw/rtl/smm_ctrl.sv
hw/rtl/smm_dp.sv
hw/rtl/switch_event_midi_mapper.sv
bench/switch_event_midi_mapper_tb.sv
